>>> rtl/core/mce_pkg.sv
// shared types, constants and the character lookup for the morse encoder
`default_nettype none

package mce_pkg;

    localparam int MCE_QDEPTH = 2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DUR_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DOT_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TIME = 2'd2;

    localparam logic [DUR_W-1:0] DOT_TIME_RST = 16'd200;
    localparam logic [DUR_W-1:0] DASH_TIME_RST = 16'd1000;
    localparam logic [DUR_W-1:0] GAP_TIME_RST = 16'd500;

    localparam logic [7:0] ASCII_A = 8'd65;
    localparam logic [7:0] ASCII_0 = 8'd48;
    localparam logic [7:0] DIGIT_ROW0 = 8'd26;

    // {symbol count, pattern}; pattern bit i is symbol i, 1 = dash
    localparam logic [7:0] SYM_TABLE [36] = '{
        {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
        {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
        {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
        {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
        {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
        {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
        {3'd4, 5'b01101}, {3'd4, 5'b00011},
        {3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
        {3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
        {3'd5, 5'b00111}, {3'd5, 5'b01111}
    };

    typedef struct packed {
        logic       bad;
        logic [2:0] len;
        logic [4:0] pat;
        logic       wend;
    } t_entry;

    typedef struct packed {
        logic [DUR_W-1:0] dot;
        logic [DUR_W-1:0] dash;
        logic [DUR_W-1:0] gap;
    } t_cfg;

    typedef struct packed {
        logic             lamp_on;
        logic [DUR_W-1:0] duration_ms;
        logic             char_done;
        logic             word_done;
        logic             bad_char;
    } t_result;

    function automatic t_entry classify(input logic [7:0] code, input logic wend);
        t_entry     e;
        logic [7:0] row;
        logic [7:0] sym;
        e.bad = 1'b0;
        e.len = 3'd0;
        e.pat = 5'd0;
        e.wend = wend;
        row = 8'd0;
        case (code) inside
            [8'd65:8'd90]: row = code - ASCII_A;
            [8'd48:8'd57]: row = code - ASCII_0 + DIGIT_ROW0;
            default:       e.bad = 1'b1;
        endcase
        if (!e.bad) begin
            sym = SYM_TABLE[row[5:0]];
            e.len = sym[7:5];
            e.pat = sym[4:0];
        end
        return e;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mce_front.sv
// front stage: takes characters and turns them into queue entries
`default_nettype none

module mce_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [7:0]      i_char_code,
    input  wire logic            i_word_end,
    output logic                 o_push,
    output mce_pkg::t_entry      o_push_entry,
    input  wire logic            i_q_full
);
    import mce_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    logic   take;

    assign o_push = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign take = i_in_valid && !o_in_stall;
    assign o_push_entry = r_entry;

    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_entry <= classify(i_char_code, i_word_end);
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mce_fifo.sv
// short queue of classified characters between front and back
`default_nettype none

module mce_fifo #(
    parameter int DEPTH = mce_pkg::MCE_QDEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mce_pkg::t_entry i_push_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output mce_pkg::t_entry      o_head,
    output logic                 o_valid
);
    import mce_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;
    logic [CW-1:0] n_count;

    assign o_full = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mce_back.sv
// back stage: walks symbols and emits one segment per cycle unless stalled
`default_nettype none

module mce_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mce_pkg::t_cfg   i_cfg,
    input  wire mce_pkg::t_entry i_head,
    input  wire logic            i_head_valid,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output mce_pkg::t_result     o_result
);
    import mce_pkg::*;

    logic    r_busy;
    logic    n_busy;
    t_entry  r_ent;
    logic [3:0] r_seg;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;

    t_entry     cur;
    logic       cur_valid;
    logic [3:0] seg;
    logic [2:0] sym;
    logic       last;
    logic       out_free;
    logic       emit;
    t_result    res;

    assign cur = r_busy ? r_ent : i_head;
    assign cur_valid = r_busy || i_head_valid;
    assign seg = r_busy ? r_seg : 4'd0;
    assign sym = seg[3:1];
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit = out_free && cur_valid;
    assign o_pop = emit && !r_busy;

    // for a valid character, even segment lights the lamp, odd segment is the pause after it
    always_comb begin
        last = cur.bad || (seg[0] && ({1'b0, sym} + 4'd1 == {1'b0, cur.len}));
        res.lamp_on = !cur.bad && !seg[0];
        if (cur.bad) begin
            res.duration_ms = '0;
        end else if (seg[0]) begin
            res.duration_ms = i_cfg.gap;
        end else if (cur.pat[sym]) begin
            res.duration_ms = i_cfg.dash;
        end else begin
            res.duration_ms = i_cfg.dot;
        end
        res.char_done = last;
        res.word_done = last && cur.wend;
        res.bad_char = cur.bad;
    end

    always_comb begin
        n_busy = r_busy;
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = cur_valid;
        end
        if (emit) begin
            n_busy = !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_result <= res;
            r_ent <= cur;
            r_seg <= seg + 4'd1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> rtl/core/morse_character_encoder.sv
// top level of the morse character encoder: registers, front, queue, back
// first segment passes the front register, queue and back output register before
// o_out_valid; a valid character of n symbols yields 2n segments, one per cycle
// unless stalled, no gap between characters; a bad character yields one segment
// the back stage's segment counter sets the rate, the queue decouples the front
// synchronous active-low reset empties the pipe and loads 200/1000/500 ms timings
`default_nettype none

module morse_character_encoder #(
    parameter int QDEPTH = mce_pkg::MCE_QDEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_char_code,
    input  wire logic                           i_word_end,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_lamp_on,
    output logic [mce_pkg::DUR_W-1:0]           o_duration_ms,
    output logic                                o_char_done,
    output logic                                o_word_done,
    output logic                                o_bad_char
);
    import mce_pkg::*;

    t_cfg    r_cfg;
    t_entry  push_entry;
    t_entry  head;
    t_result result;
    logic    push;
    logic    q_full;
    logic    pop;
    logic    head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot <= DOT_TIME_RST;
            r_cfg.dash <= DASH_TIME_RST;
            r_cfg.gap <= GAP_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DOT_TIME:  r_cfg.dot <= i_cfg_data;
                REG_DASH_TIME: r_cfg.dash <= i_cfg_data;
                REG_GAP_TIME:  r_cfg.gap <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    mce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_code  (i_char_code),
        .i_word_end   (i_word_end),
        .o_push       (push),
        .o_push_entry (push_entry),
        .i_q_full     (q_full)
    );

    mce_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head       (head),
        .o_valid      (head_valid)
    );

    mce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (result)
    );

    assign o_lamp_on = result.lamp_on;
    assign o_duration_ms = result.duration_ms;
    assign o_char_done = result.char_done;
    assign o_word_done = result.word_done;
    assign o_bad_char = result.bad_char;

    // a bad character is a single dark zero-length segment that closes it
    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_char |-> o_char_done && !o_lamp_on && o_duration_ms == '0)
        else $error("bad character segment malformed");

    // every character ends on a pause, never on a lit segment
    a_lit_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_lamp_on |-> !o_char_done && !o_word_done)
        else $error("lit segment marked as last");

    a_word_needs_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_done |-> o_char_done)
        else $error("word end without character end");

    // the queue is never popped when empty nor pushed when full
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && !head_valid) && !(push && q_full))
        else $error("queue overrun or underrun");

endmodule

`default_nettype wire

>>> sim/tb_morse_character_encoder.sv
// testbench for the morse character encoder: directed and random characters against a predictor
`default_nettype none

module tb_morse_character_encoder;
    import mce_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [7:0] CHAR_Z = 8'h5A;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam int MAX_PRINTED = 20;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic [7:0] char_code;
    logic word_end;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic lamp_on;
    logic [DUR_W-1:0] duration_ms;
    logic char_done;
    logic word_done;
    logic bad_char;

    // dots and dashes per character
    string letter_code [26] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
    };
    string digit_code [10] = '{
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    t_cfg timing;
    t_result segments_due [$];
    int idle_max = 12;
    int stall_left = 0;
    int mismatches = 0;
    int chars_sent = 0;
    int bad_sent = 0;
    int segments_seen = 0;
    int reg_writes = 0;

    morse_character_encoder dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_char_code   (char_code),
        .i_word_end    (word_end),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_lamp_on     (lamp_on),
        .o_duration_ms (duration_ms),
        .o_char_done   (char_done),
        .o_word_done   (word_done),
        .o_bad_char    (bad_char)
    );

    always #5 clk = ~clk;

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic int draw_wait();
        if (idle_max == 0)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, idle_max);
    endfunction

    // expected segments of one character under the current timing
    task automatic encode_char(input logic [7:0] code, input logic wend);
        string syms;
        t_result seg;
        logic last;
        if (code >= ASCII_A && code <= CHAR_Z) begin
            syms = letter_code[code - ASCII_A];
        end else if (code >= ASCII_0 && code <= CHAR_9) begin
            syms = digit_code[code - ASCII_0];
        end else begin
            seg = '{lamp_on: 1'b0, duration_ms: '0, char_done: 1'b1,
                    word_done: wend, bad_char: 1'b1};
            segments_due.push_back(seg);
            bad_sent++;
            return;
        end
        for (int i = 0; i < syms.len(); i++) begin
            last = (i == syms.len() - 1);
            seg = '{lamp_on: 1'b1, duration_ms: (syms[i] == "-") ? timing.dash : timing.dot,
                    char_done: 1'b0, word_done: 1'b0, bad_char: 1'b0};
            segments_due.push_back(seg);
            seg = '{lamp_on: 1'b0, duration_ms: timing.gap, char_done: last,
                    word_done: last & wend, bad_char: 1'b0};
            segments_due.push_back(seg);
        end
    endtask

    task automatic send_char(input logic [7:0] code, input logic wend);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= code;
        word_end <= wend;
        do @(posedge clk); while (in_stall);
        encode_char(code, wend);
        chars_sent++;
    endtask

    function automatic logic [7:0] random_char(input int bad_pct);
        int row;
        if ($urandom_range(1, 100) <= bad_pct)
            return 8'($urandom_range(0, 255));
        row = $urandom_range(0, 35);
        return (row < 26) ? ASCII_A + 8'(row) : ASCII_0 + 8'(row - 26);
    endfunction

    // leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_DOT_TIME:  timing.dot = val;
            REG_DASH_TIME: timing.dash = val;
            REG_GAP_TIME:  timing.gap = val;
            default:       ;
        endcase
        reg_writes++;
    endtask

    task automatic load_timing(input logic [DUR_W-1:0] dot, input logic [DUR_W-1:0] dash,
                               input logic [DUR_W-1:0] gap);
        write_reg(REG_DOT_TIME, dot);
        write_reg(REG_DASH_TIME, dash);
        write_reg(REG_GAP_TIME, gap);
        cfg_we <= 1'b0;
    endtask

    // let every expected segment come out before touching the registers
    task automatic drain();
        in_valid <= 1'b0;
        while (segments_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_timing();
        logic [7:0] valid_chars [8] = '{"A", "B", "E", "T", "Z", "0", "5", "9"};
        logic [7:0] odd_chars [9] = '{8'h00, 8'hFF, "@", "[", "/", ":", "a", "z", 8'h80};
        foreach (valid_chars[i])
            send_char(valid_chars[i], i[0]);
        foreach (odd_chars[i])
            send_char(odd_chars[i], ~i[0]);
        drain();
    endtask

    task automatic test_timing_extremes();
        load_timing('0, '0, '0);
        send_char("Q", 1'b1);
        send_char("7", 1'b0);
        drain();
        load_timing('1, '1, '1);
        send_char("H", 1'b0);
        send_char("0", 1'b1);
        drain();
        load_timing(16'h0001, 16'hFFFF, 16'h8000);
        send_char("K", 1'b1);
        drain();
        // the spare index has no register behind it
        write_reg(REG_SPARE, 16'h5A5A);
        cfg_we <= 1'b0;
        send_char("R", 1'b1);
        send_char("#", 1'b1);
        drain();
    endtask

    function automatic logic [DUR_W-1:0] random_time();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return DUR_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_random_text();
        for (int phase = 0; phase < 6; phase++) begin
            idle_max = (phase == 2) ? 0 : 12;
            load_timing(random_time(), random_time(), random_time());
            for (int n = 0; n < 50; n++)
                send_char(random_char(15), 1'($urandom_range(0, 1)));
            drain();
        end
        idle_max = 12;
    endtask

    // result side: receiver stalls and every transfer is checked in order
    always @(posedge clk) begin
        t_result want;
        int n;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            segments_seen++;
            if (segments_due.size() == 0) begin
                report("unexpected segment, lamp_on", lamp_on, 0);
            end else begin
                want = segments_due.pop_front();
                if (lamp_on !== want.lamp_on) report("lamp_on", lamp_on, want.lamp_on);
                if (duration_ms !== want.duration_ms)
                    report("duration_ms", duration_ms, want.duration_ms);
                if (char_done !== want.char_done) report("char_done", char_done, want.char_done);
                if (word_done !== want.word_done) report("word_done", word_done, want.word_done);
                if (bad_char !== want.bad_char) report("bad_char", bad_char, want.bad_char);
            end
            n = draw_wait();
            out_stall <= (n > 0);
            stall_left <= n;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
    end

    initial begin
        timing = '{dot: DOT_TIME_RST, dash: DASH_TIME_RST, gap: GAP_TIME_RST};
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        char_code <= '0;
        word_end <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_timing();
        test_timing_extremes();
        test_random_text();

        repeat (12) @(posedge clk);
        if (segments_due.size() != 0)
            report("segments never seen", 0, segments_due.size());
        $display("sent %0d characters (%0d not in the table), checked %0d segments",
                 chars_sent, bad_sent, segments_seen);
        $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
